/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/vbc_pkg.sv */
// ---------------------------------------------------------------------------
// vbc_pkg
// Types, limit tables and codes shared by the voltage bin classifier.
// ---------------------------------------------------------------------------
package vbc_pkg;

  // Lot code compare values, four low base-36 digits
  localparam logic [20:0] LOT_CODE_A = 21'd1674066;
  localparam logic [20:0] LOT_CODE_B = 21'd1674115;
  localparam logic [20:0] LOT_MOD    = 21'd1679616;  // 36^4

  localparam int NEW_N = 13;
  localparam int OLD_N = 12;
  localparam int MIF_N = 4;

  localparam logic [9:0] NEW_HPM [NEW_N] =
    '{10'd6, 10'd8, 10'd9, 10'd10, 10'd12, 10'd13, 10'd14, 10'd16, 10'd17,
      10'd19, 10'd20, 10'd100, 10'd999};
  localparam logic [9:0] NEW_IDS [NEW_N] =
    '{10'd7, 10'd9, 10'd10, 10'd11, 10'd13, 10'd15, 10'd17, 10'd21, 10'd25,
      10'd32, 10'd39, 10'd100, 10'd999};
  localparam logic [9:0] OLD_HPM [OLD_N] =
    '{10'd0, 10'd9, 10'd10, 10'd12, 10'd14, 10'd15, 10'd16, 10'd17, 10'd18,
      10'd19, 10'd100, 10'd999};
  localparam logic [9:0] OLD_IDS [OLD_N] =
    '{10'd0, 10'd7, 10'd9, 10'd11, 10'd14, 10'd17, 10'd20, 10'd23, 10'd27,
      10'd30, 10'd100, 10'd999};
  localparam logic [9:0] MIF_HPM [MIF_N] = '{10'd0, 10'd12, 10'd15, 10'd100};

  localparam logic [7:0] IDS_CORR = 8'd16;

  typedef enum logic [1:0] {
    BIAS_0V8    = 2'd0,
    BIAS_BYPASS = 2'd1,
    BIAS_1V3    = 2'd2,
    BIAS_KEEP   = 2'd3
  } bias_t;

  typedef struct packed {
    logic [4:0] wafer;
    logic       first;
    logic       special;
  } lot_info_t;

  typedef struct packed {
    logic       fused;
    logic [3:0] asv;
    logic [3:0] mif;
    logic       special;
    logic       first;
    logic [4:0] hpm;
    logic [7:0] ids;
    bias_t      bias_main;
    bias_t      bias_mif;
  } res_t;

endpackage

/* hdl/voltage_bin_classifier.sv */
// ---------------------------------------------------------------------------
// voltage_bin_classifier
// Fuse-word voltage binning: supply group, memory group and body-bias modes.
// ---------------------------------------------------------------------------
// Takes one item (chip fuse word, lot fuse word) per cycle while the output
// side does not stall; each item passes the input register, then the
// classification logic into the result register, giving one result per input.
// The combinational table scan and lot decode set the rate; either register
// stage holds when the output side stalls. The user writes soc_matches through
// the cfg port while the block is idle (not enforced by the block); resets to 1.
module voltage_bin_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data,     // [0] soc_matches
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,     // [31:0] chip_id_word, [63:32] lot_id_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [3:0] asv_group, [7:4] mif_group,
                                    // [8] lot_special, [9] lot_first_code,
                                    // [14:10] hpm_value, [22:15] ids_value,
                                    // [24:23] bias_main_mode,
                                    // [26:25] bias_mif_mode, [31:27] zero
  output logic [0:0]  out_tuser     // [0] speed_group_fused
);

  logic               soc_r;
  logic               s1_v_r;
  logic [31:0]        s1_chip_r;
  logic [31:0]        s1_lot_r;
  logic               out_v_r;
  vbc_pkg::res_t      out_res_r;
  logic               s2_ready;
  logic               s1_ready;
  vbc_pkg::lot_info_t lot_info;
  vbc_pkg::res_t      res;

  assign cfg_ready = 1'b1;
  assign s2_ready  = !out_v_r || out_tready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soc_r   <= 1'b1;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_valid) soc_r <= cfg_data[0];
      if (s1_ready) s1_v_r <= in_tvalid;
      if (s2_ready) out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s1_ready) begin
      s1_chip_r <= in_tdata[31:0];
      s1_lot_r  <= in_tdata[63:32];
    end
    if (s1_v_r && s2_ready) out_res_r <= res;
  end

  vbc_lot_decode u_lot (
    .lot_word (s1_lot_r),
    .info     (lot_info)
  );

  vbc_judge u_judge (
    .chip_word   (s1_chip_r),
    .lot         (lot_info),
    .soc_matches (soc_r),
    .res         (res)
  );

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.fused;
  assign out_tdata  = {5'b0, out_res_r.bias_mif, out_res_r.bias_main, out_res_r.ids,
                       out_res_r.hpm, out_res_r.first, out_res_r.special,
                       out_res_r.mif, out_res_r.asv};

endmodule

/* hdl/vbc_lot_decode.sv */
// ---------------------------------------------------------------------------
// vbc_lot_decode
// Bit-reverses the lot word, reduces the lot code and matches special lots.
// ---------------------------------------------------------------------------
module vbc_lot_decode (
  input  logic [31:0]        lot_word,
  output vbc_pkg::lot_info_t info
);

  logic [31:0] rev;
  logic [20:0] code;
  logic [20:0] code_red;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      rev[i] = lot_word[31 - i];
    end
  end

  // 21-bit code is below twice 36^4: one compare and subtract
  assign code     = rev[31:11];
  assign code_red = (code >= vbc_pkg::LOT_MOD) ? code - vbc_pkg::LOT_MOD : code;

  assign info.wafer   = rev[10:6];
  assign info.first   = (code_red == vbc_pkg::LOT_CODE_A);
  assign info.special = (code_red == vbc_pkg::LOT_CODE_A) ||
                        (code_red == vbc_pkg::LOT_CODE_B);

endmodule

/* hdl/vbc_judge.sv */
// ---------------------------------------------------------------------------
// vbc_judge
// Fused-group path, IDS correction, limit table scans and bias selection.
// ---------------------------------------------------------------------------
module vbc_judge (
  input  logic [31:0]        chip_word,
  input  vbc_pkg::lot_info_t lot,
  input  logic               soc_matches,
  output vbc_pkg::res_t      res
);

  logic [3:0] orig;
  logic [3:0] modg;
  logic [4:0] hpm;
  logic [7:0] ids;
  logic       corr;
  logic       ids_wrap;   // corrected IDS wrapped below zero
  logic [7:0] ids_eff;
  logic [vbc_pkg::NEW_N-1:0] new_hit;
  logic [vbc_pkg::OLD_N-1:0] old_hit;
  logic [vbc_pkg::MIF_N-1:0] mif_hit;
  logic [3:0] new_grp;
  logic [3:0] old_grp;
  logic [3:0] mif_grp;
  logic [3:0] grp;
  logic [3:0] grp_cl;

  assign orig = chip_word[20:17];
  assign modg = {1'b0, chip_word[23:21]};
  assign hpm  = chip_word[16:12];
  assign ids  = chip_word[31:24];

  assign corr     = lot.first && (lot.wafer >= 5'd2) && (lot.wafer <= 5'd6);
  assign ids_wrap = corr && (ids < vbc_pkg::IDS_CORR);
  assign ids_eff  = corr ? ids - vbc_pkg::IDS_CORR : ids;

  always_comb begin
    for (int i = 0; i < vbc_pkg::NEW_N; i++) begin
      new_hit[i] = (!ids_wrap && ({2'b0, ids_eff} <= vbc_pkg::NEW_IDS[i])) ||
                   ({5'b0, hpm} <= vbc_pkg::NEW_HPM[i]);
    end
    for (int i = 0; i < vbc_pkg::OLD_N; i++) begin
      old_hit[i] = (!ids_wrap && ({2'b0, ids_eff} <= vbc_pkg::OLD_IDS[i])) ||
                   ({5'b0, hpm} <= vbc_pkg::OLD_HPM[i]);
    end
    for (int i = 0; i < vbc_pkg::MIF_N; i++) begin
      mif_hit[i] = ({5'b0, hpm} <= vbc_pkg::MIF_HPM[i]);
    end
  end

  // First match wins: scan from the top so the lowest hit is kept
  always_comb begin
    new_grp = '0;
    old_grp = '0;
    mif_grp = '0;
    for (int i = vbc_pkg::NEW_N - 1; i >= 0; i--) begin
      if (new_hit[i]) new_grp = 4'(i);
    end
    for (int i = vbc_pkg::OLD_N - 1; i >= 0; i--) begin
      if (old_hit[i]) old_grp = 4'(i);
    end
    for (int i = vbc_pkg::MIF_N - 1; i >= 0; i--) begin
      if (mif_hit[i]) mif_grp = 4'(i);
    end
  end

  assign grp    = !soc_matches ? 4'd0 : (lot.special ? old_grp : new_grp);
  assign grp_cl = (grp == 4'd0) ? 4'd1 : grp;

  always_comb begin
    res           = '0;
    res.bias_main = vbc_pkg::BIAS_KEEP;
    res.bias_mif  = vbc_pkg::BIAS_KEEP;
    if (chip_word[3]) begin
      res.fused = 1'b1;
      if (orig == 4'd0 || orig <= modg) begin
        res.asv = 4'd1;
      end else begin
        res.asv = orig - modg;
      end
    end else begin
      res.asv     = grp_cl;
      res.special = lot.special;
      res.first   = lot.first;
      res.hpm     = hpm;
      res.ids     = ids;
      if (soc_matches) begin
        res.mif = lot.special ? old_grp : mif_grp;
      end
      if (!lot.special) begin
        res.bias_main = (grp_cl <= 4'd1) ? vbc_pkg::BIAS_0V8 : vbc_pkg::BIAS_BYPASS;
        res.bias_mif  = vbc_pkg::BIAS_1V3;
      end else begin
        priority if (grp_cl <= 4'd2) begin
          res.bias_main = vbc_pkg::BIAS_0V8;
        end else if (grp_cl <= 4'd4) begin
          res.bias_main = vbc_pkg::BIAS_BYPASS;
        end else begin
          res.bias_main = vbc_pkg::BIAS_1V3;
        end
        res.bias_mif = res.bias_main;
      end
    end
  end

endmodule

/* hdl/vbc_checker.sv */
// ---------------------------------------------------------------------------
// vbc_checker
// Port-level checks on the classifier result stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  logic        out_stall;
  logic [32:0] out_bus;
  logic [3:0]  asv;
  logic        fused_item;
  logic        fused_clean;
  logic        lot_special;
  logic        first_item;
  logic        normal_item;
  logic        mif_bias_ok;

  assign out_stall   = out_tvalid && !out_tready;
  assign out_bus     = {out_tuser, out_tdata};
  assign asv         = out_tdata[3:0];
  assign fused_item  = out_tvalid && out_tuser[0];
  assign fused_clean = (out_tdata[7:4] == 4'd0) && (out_tdata[22:8] == 15'd0) &&
                       (out_tdata[24:23] == vbc_pkg::BIAS_KEEP) &&
                       (out_tdata[26:25] == vbc_pkg::BIAS_KEEP);
  assign lot_special = out_tdata[8];
  assign first_item  = out_tvalid && out_tdata[9];
  assign normal_item = out_tvalid && !out_tuser[0] && !out_tdata[8];
  assign mif_bias_ok = (out_tdata[26:25] == vbc_pkg::BIAS_1V3);

  // stalled result item holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_bus), "item changed")

  // supply group is clamped to at least 1
  `ASSERT_ALWAYS(a_asv_nonzero, clk, rst_n, !out_tvalid || asv != 4'd0, "asv group is zero")

  // fused path leaves biases unchanged and memory group zero
  `ASSERT_ALWAYS(a_fused_fields, clk, rst_n, !fused_item || fused_clean, "fused fields set")

  // first special code is a special code
  `ASSERT_ALWAYS(a_first_special, clk, rst_n, !first_item || lot_special, "first not special")

  // normal lot on table path: memory bias at 1.3V
  `ASSERT_ALWAYS(a_normal_mif_bias, clk, rst_n, !normal_item || mif_bias_ok, "mif bias")

endmodule

bind voltage_bin_classifier vbc_checker u_vbc_checker (.*);
